// ----- hdl/spc_pkg.sv -----
// Shared constants, register codes and fixed-point helpers for the sinusoidal PWM block.
// No dependencies; imported by spc_sincos, spc_duty and sine_pwm_inverse_park_clarke.
package spc_pkg;

  // angle format: one full turn is 2^ANGLE_BITS
  localparam int ANGLE_BITS = 16;

  // pipeline depths
  localparam int SIN_STAGES  = 6;
  localparam int DIV_STAGES  = 17;
  localparam int PIPE_STAGES = SIN_STAGES + 3 + 1 + DIV_STAGES;

  // sine polynomial, Q30
  localparam logic [30:0] QTURN  = 31'd1073741824;
  localparam logic [30:0] COEF_A = 31'd1686629713;
  localparam logic [30:0] COEF_B = 31'd693598564;
  localparam logic [30:0] COEF_C = 31'd85569278;
  localparam logic [30:0] COEF_D = 31'd5026995;

  // sqrt(3)/2 in Q15
  localparam logic signed [15:0] HALF_SQRT3 = 16'sd28378;

  // datapath widths
  localparam int SC_W    = 17;  // signed sine/cosine, Q15
  localparam int ALPHA_W = 34;  // alpha/beta, Q23
  localparam int SB_W    = 50;  // beta * sqrt(3)/2
  localparam int X_W     = 50;  // duty numerator
  localparam int DEN_W   = 45;  // supply * 2^30
  localparam int T_W     = DEN_W + 2;
  localparam int CMP_W   = 17;  // compare value and scale

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_VOLT_CLAMP     = 2'd0,
    REG_SUPPLY_VOLTAGE = 2'd1,
    REG_PWM_PERIOD     = 2'd2
  } cfg_reg_t;

  // (a * b) >> 30 where the result is known to fit 31 bits
  function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b);
    return p[60:30];
  endfunction

endpackage

// ----- hdl/sine_pwm_inverse_park_clarke.sv -----
// Sinusoidal PWM: d/q clamp, inverse Park/Clarke, duty normalize and compare scaling.
// One beat per cycle sustained while no output beat is stalled.
// Sine polynomial takes 6 stages, the quotient pipeline 17 stages, one bit of scale each.
// The whole pipeline holds while an output beat is stalled.
// rst (synchronous) empties the pipeline and loads register defaults.
// Depends on spc_pkg, spc_sincos, spc_duty.
module sine_pwm_inverse_park_clarke (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_write,
  input  logic [1:0]                 cfg_index,
  input  logic [15:0]                cfg_data,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [15:0]         volt_q,
  input  logic signed [15:0]         volt_d,
  input  logic [15:0]                elec_angle,
  // output channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [spc_pkg::CMP_W-1:0]  phase_a_compare,
  output logic [spc_pkg::CMP_W-1:0]  phase_b_compare,
  output logic [spc_pkg::CMP_W-1:0]  phase_c_compare
);
  import spc_pkg::*;

  logic [14:0] volt_clamp;
  logic [14:0] supply_voltage;
  logic [15:0] pwm_period;

  logic en;
  logic vld [PIPE_STAGES];

  logic signed [16:0] lim;
  logic signed [15:0] vq_clamp;
  logic signed [15:0] vd_clamp;
  logic signed [15:0] vq_pipe [SIN_STAGES];
  logic signed [15:0] vd_pipe [SIN_STAGES];

  logic signed [SC_W-1:0]    sin_val;
  logic signed [SC_W-1:0]    cos_val;
  logic signed [ALPHA_W-1:0] alpha7;
  logic signed [ALPHA_W-1:0] beta7;
  logic signed [ALPHA_W-1:0] alpha8;
  logic signed [SB_W-1:0]    sb8;
  logic signed [X_W-1:0]     base;
  logic signed [X_W-1:0]     xa;
  logic signed [X_W-1:0]     xb;
  logic signed [X_W-1:0]     xc;
  logic [DEN_W-1:0]          den;
  logic [CMP_W-1:0]          scale;
  logic [CMP_W-1:0]          cmp_a;
  logic [CMP_W-1:0]          cmp_b;
  logic [CMP_W-1:0]          cmp_c;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      volt_clamp     <= 15'd1382;
      supply_voltage <= 15'd3072;
      pwm_period     <= 16'd4199;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VOLT_CLAMP:     volt_clamp     <= cfg_data[14:0];
        REG_SUPPLY_VOLTAGE: supply_voltage <= cfg_data[14:0];
        REG_PWM_PERIOD:     pwm_period     <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: hold everything while the output beat waits
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_STAGES; i++) vld[i] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < PIPE_STAGES; i++) vld[i] <= vld[i-1];
      out_valid <= vld[PIPE_STAGES-1];
    end
  end

  // symmetric voltage clamp
  assign lim = $signed({2'b00, volt_clamp});
  always_comb begin
    if (17'(volt_q) > lim)       vq_clamp = lim[15:0];
    else if (17'(volt_q) < -lim) vq_clamp = 16'(-lim);
    else                         vq_clamp = volt_q;
    if (17'(volt_d) > lim)       vd_clamp = lim[15:0];
    else if (17'(volt_d) < -lim) vd_clamp = 16'(-lim);
    else                         vd_clamp = volt_d;
  end

  // voltages wait alongside the sine pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      vq_pipe[0] <= vq_clamp;
      vd_pipe[0] <= vd_clamp;
      for (int i = 1; i < SIN_STAGES; i++) begin
        vq_pipe[i] <= vq_pipe[i-1];
        vd_pipe[i] <= vd_pipe[i-1];
      end
    end
  end

  spc_sincos u_sincos (
    .clk        (clk),
    .en         (en),
    .elec_angle (elec_angle),
    .sin_val    (sin_val),
    .cos_val    (cos_val)
  );

  // inverse Park, then beta * sqrt(3)/2, then phase numerators
  assign base = $signed(X_W'({supply_voltage, 29'd0}));

  always_ff @(posedge clk) begin
    if (en) begin
      alpha7 <= ALPHA_W'(vd_pipe[SIN_STAGES-1] * cos_val)
              - ALPHA_W'(vq_pipe[SIN_STAGES-1] * sin_val);
      beta7  <= ALPHA_W'(vd_pipe[SIN_STAGES-1] * sin_val)
              + ALPHA_W'(vq_pipe[SIN_STAGES-1] * cos_val);
      alpha8 <= alpha7;
      sb8    <= SB_W'(beta7) * SB_W'(HALF_SQRT3);
      xa     <= base + (X_W'(alpha8) <<< 15);
      xb     <= base - (X_W'(alpha8) <<< 14) + X_W'(sb8);
      xc     <= base - (X_W'(alpha8) <<< 14) - X_W'(sb8);
    end
  end

  assign den   = DEN_W'({supply_voltage, 30'd0});
  assign scale = CMP_W'(pwm_period) + CMP_W'(1);

  spc_duty u_duty_a (.clk(clk), .en(en), .x(xa), .den(den), .scale(scale), .compare(cmp_a));
  spc_duty u_duty_b (.clk(clk), .en(en), .x(xb), .den(den), .scale(scale), .compare(cmp_b));
  spc_duty u_duty_c (.clk(clk), .en(en), .x(xc), .den(den), .scale(scale), .compare(cmp_c));

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      phase_a_compare <= cmp_a;
      phase_b_compare <= cmp_b;
      phase_c_compare <= cmp_c;
    end
  end

  // checks
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting output beat");

  a_cmp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (phase_a_compare <= scale) && (phase_b_compare <= scale)
                  && (phase_c_compare <= scale))
    else $error("compare value above period plus one");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat right after reset");

endmodule

// ----- hdl/spc_sincos.sv -----
// Pipelined sine/cosine generator: quarter-wave polynomial, at most one multiply per stage in each channel.
// Depends on spc_pkg. The pipeline advances only while en is high.
module spc_sincos (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [15:0]                          elec_angle,
  output logic signed [spc_pkg::SC_W-1:0]      sin_val,
  output logic signed [spc_pkg::SC_W-1:0]      cos_val
);
  import spc_pkg::*;

  // channel 0 is sine, channel 1 is cosine
  logic [31:0] phase;
  logic [30:0] r_lo;
  logic [30:0] z1  [2];
  logic        n1  [2];
  logic [30:0] z2r [2];
  logic [30:0] z2  [2];
  logic        n2  [2];
  logic [30:0] t3r [2];
  logic [30:0] z3  [2];
  logic [30:0] sq3 [2];
  logic        n3  [2];
  logic [30:0] t4r [2];
  logic [30:0] z4  [2];
  logic [30:0] sq4 [2];
  logic        n4  [2];
  logic [30:0] t5r [2];
  logic [30:0] z5  [2];
  logic        n5  [2];
  logic [61:0] m_prod [2];
  logic [15:0] mag    [2];
  logic signed [SC_W-1:0] res [2];

  // wrap the angle onto a 32-bit turn
  assign phase = 32'(elec_angle) << (32 - ANGLE_BITS);
  assign r_lo  = {1'b0, phase[29:0]};

  // stage 1: fold into the first quadrant
  always_ff @(posedge clk) begin
    if (en) begin
      z1[0] <= phase[30] ? (QTURN - r_lo) : r_lo;
      z1[1] <= phase[30] ? r_lo : (QTURN - r_lo);
      n1[0] <= phase[31];
      n1[1] <= phase[31] ^ phase[30];
    end
  end

  // stages 2..6 per channel
  for (genvar ch = 0; ch < 2; ch++) begin : g_ch
    always_ff @(posedge clk) begin
      if (en) begin
        z2r[ch] <= mul_q30(z1[ch], z1[ch]);
        z2[ch]  <= z1[ch];
        n2[ch]  <= n1[ch];
        t3r[ch] <= COEF_C - mul_q30(z2r[ch], COEF_D);
        sq3[ch] <= z2r[ch];
        z3[ch]  <= z2[ch];
        n3[ch]  <= n2[ch];
        t4r[ch] <= COEF_B - mul_q30(sq3[ch], t3r[ch]);
        sq4[ch] <= sq3[ch];
        z4[ch]  <= z3[ch];
        n4[ch]  <= n3[ch];
        t5r[ch] <= COEF_A - mul_q30(sq4[ch], t4r[ch]);
        z5[ch]  <= z4[ch];
        n5[ch]  <= n4[ch];
        res[ch] <= n5[ch] ? -$signed({1'b0, mag[ch]}) : $signed({1'b0, mag[ch]});
      end
    end

    // final product truncated to Q15
    assign m_prod[ch] = 62'(z5[ch]) * 62'(t5r[ch]);
    assign mag[ch]    = m_prod[ch][60:45];
  end

  assign sin_val = res[0];
  assign cos_val = res[1];

endmodule

// ----- hdl/spc_duty.sv -----
// Duty clamp and compare scaling: floor(scale * x / den) by a one-bit-per-stage divider.
// Depends on spc_pkg. Stages advance only while en is high; the output is combinational from the last stage.
module spc_duty (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [spc_pkg::X_W-1:0]     x,
  input  logic [spc_pkg::DEN_W-1:0]          den,
  input  logic [spc_pkg::CMP_W-1:0]          scale,
  output logic [spc_pkg::CMP_W-1:0]          compare
);
  import spc_pkg::*;

  logic [DEN_W-1:0] xs [DIV_STAGES+1];
  logic [DEN_W-1:0] rm [DIV_STAGES+1];
  logic [CMP_W-1:0] qt [DIV_STAGES+1];
  logic             lo [DIV_STAGES+1];
  logic             hi [DIV_STAGES+1];

  // stage 0: range check
  always_ff @(posedge clk) begin
    if (en) begin
      lo[0] <= (x <= 0);
      hi[0] <= (x >= $signed(X_W'(den)));
      xs[0] <= x[DEN_W-1:0];
      rm[0] <= '0;
      qt[0] <= '0;
    end
  end

  // one bit of scale per stage, MSB first; digit is 0..2
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    logic [T_W-1:0] t;
    logic [T_W-1:0] d1;
    logic [T_W-1:0] d2;
    logic [T_W-1:0] r;
    logic [1:0]     dig;

    always_comb begin
      d1 = T_W'(den);
      d2 = T_W'(den) << 1;
      t  = (T_W'(rm[k-1]) << 1) + (scale[CMP_W-k] ? T_W'(xs[k-1]) : '0);
      if (t >= d2) begin
        r   = t - d2;
        dig = 2'd2;
      end else if (t >= d1) begin
        r   = t - d1;
        dig = 2'd1;
      end else begin
        r   = t;
        dig = 2'd0;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm[k] <= r[DEN_W-1:0];
        qt[k] <= (qt[k-1] << 1) + CMP_W'(dig);
        xs[k] <= xs[k-1];
        lo[k] <= lo[k-1];
        hi[k] <= hi[k-1];
      end
    end
  end

  // saturate at both ends
  assign compare = lo[DIV_STAGES] ? '0 : (hi[DIV_STAGES] ? scale : qt[DIV_STAGES]);

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for sine_pwm_inverse_park_clarke: directed corners, then random beats.
// Uses spc_pkg for register codes; predicts compare values with its own fixed-point model.
// The scoreboard class holds register mirrors and the queue of pending compare triples.
class pwm_scoreboard;
  typedef struct {
    logic [16:0] cmp_a;
    logic [16:0] cmp_b;
    logic [16:0] cmp_c;
  } cmp_triple_t;

  cmp_triple_t pending[$];
  int unsigned vlim = 1382;
  int unsigned vsup = 3072;
  int unsigned period = 4199;
  int errors = 0;
  int checked = 0;

  // sine of a 32-bit turn, Q15, quarter-wave polynomial with Q30 truncation
  function automatic longint sine_q15(logic [31:0] p);
    logic [63:0] r, z, z2, t, m;
    r = {34'd0, p[29:0]};
    z = p[30] ? (64'd1073741824 - r) : r;
    z2 = (z * z) >> 30;
    t = 64'd5026995;
    t = 64'd85569278 - ((z2 * t) >> 30);
    t = 64'd693598564 - ((z2 * t) >> 30);
    t = 64'd1686629713 - ((z2 * t) >> 30);
    m = ((z * t) >> 30) >> 15;
    return p[31] ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [16:0] duty_to_cmp(longint u_q38);
    longint unit, x, dn;
    logic [63:0] scale;
    unit = longint'(vsup) * 64'sd1073741824;
    x = unit + 2 * u_q38;
    dn = 2 * unit;
    scale = 64'(period) + 64'd1;
    if (x <= 0) return 17'd0;
    if (x >= dn) return scale[16:0];
    return 17'((scale * 64'(x)) / 64'(dn));
  endfunction

  function automatic int clamp(logic signed [15:0] v);
    int lim;
    lim = int'(vlim);
    if (int'(v) > lim) return lim;
    if (int'(v) < -lim) return -lim;
    return int'(v);
  endfunction

  function void set_reg(logic [1:0] idx, logic [15:0] data);
    if (idx == spc_pkg::REG_VOLT_CLAMP) vlim = data[14:0];
    else if (idx == spc_pkg::REG_SUPPLY_VOLTAGE) vsup = data[14:0];
    else if (idx == spc_pkg::REG_PWM_PERIOD) period = data;
  endfunction

  // accepted input beat: compute the three compare values
  function void note_input(logic signed [15:0] vq_in, logic signed [15:0] vd_in,
                           logic [15:0] ang);
    longint vq, vd, s, c, alpha, beta, half, sb;
    logic [31:0] p;
    cmp_triple_t e;
    vq = clamp(vq_in);
    vd = clamp(vd_in);
    p = {ang, 16'd0};
    s = sine_q15(p);
    c = sine_q15(p + 32'd1073741824);
    alpha = vd * c - vq * s;
    beta = vd * s + vq * c;
    half = alpha * 16384;
    sb = beta * 28378;
    e.cmp_a = duty_to_cmp(alpha * 32768);
    e.cmp_b = duty_to_cmp(-half + sb);
    e.cmp_c = duty_to_cmp(-half - sb);
    pending.push_back(e);
  endfunction

  // accepted output beat: compare with oldest prediction
  function void check_result(logic [16:0] a, logic [16:0] b, logic [16:0] c);
    cmp_triple_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected output beat a=%0d b=%0d c=%0d", $time, a, b, c);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (a !== e.cmp_a) begin
      $display("%0t: phase A expected %0d actual %0d", $time, e.cmp_a, a);
      errors++;
    end
    if (b !== e.cmp_b) begin
      $display("%0t: phase B expected %0d actual %0d", $time, e.cmp_b, b);
      errors++;
    end
    if (c !== e.cmp_c) begin
      $display("%0t: phase C expected %0d actual %0d", $time, e.cmp_c, c);
      errors++;
    end
  endfunction
endclass

module testbench;
  import spc_pkg::*;

  localparam logic [1:0] REG_NONE = 2'd3;  // unmapped register index

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] volt_q = '0;
  logic signed [15:0] volt_d = '0;
  logic [15:0] elec_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CMP_W-1:0] phase_a_compare, phase_b_compare, phase_c_compare;

  pwm_scoreboard sb = new();
  bit quiet = 0;        // no random idling on either side
  int hold_cycles = 0;  // long receiver hold-off request
  int beats_sent = 0;
  int cfg_sets = 0;

  sine_pwm_inverse_park_clarke u_top (.*);

  always #2 clk = ~clk;

  // receiver: random stalls, or a long counted hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 8);
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(phase_a_compare, phase_b_compare, phase_c_compare);
  end

  // one input beat; valid stays high afterwards
  task automatic send_beat(logic signed [15:0] vq, logic signed [15:0] vd, logic [15:0] ang);
    while (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    volt_q <= vq;
    volt_d <= vd;
    elec_angle <= ang;
    do @(posedge clk); while (in_stall);
    sb.note_input(vq, vd, ang);
    beats_sent++;
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
  endtask

  // wait for the pipeline to empty
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic set_config(logic [15:0] lim, logic [15:0] sup, logic [15:0] per);
    drain();
    write_reg(REG_VOLT_CLAMP, lim);
    write_reg(REG_SUPPLY_VOLTAGE, sup);
    write_reg(REG_PWM_PERIOD, per);
    cfg_sets++;
  endtask

  // voltage spread around the clamp limits (up to a quarter beyond) most of the time, full range otherwise
  function automatic logic [15:0] pick_volt();
    int span;
    if ($urandom_range(9) < 3) return 16'($urandom);
    span = int'(sb.vlim) + int'(sb.vlim) / 4 + 2;
    return 16'($urandom_range(2 * span) - span);
  endfunction

  task automatic random_beats(int n);
    repeat (n) send_beat(pick_volt(), pick_volt(), 16'($urandom));
    end_burst();
  endtask

  task automatic directed_beats();
    logic [15:0] angs[7] = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535,
                             16'd10923, 16'd1};
    foreach (angs[i]) send_beat(16'sh7FFF, 16'sh8000, angs[i]);
    send_beat(16'sh8000, 16'sh7FFF, 16'd21845);
    send_beat(16'sd0, 16'sd0, 16'd12345);
    send_beat(16'sh7FFF, 16'sh7FFF, 16'd8192);
    send_beat(16'sh8000, 16'sh8000, 16'd40000);
    send_beat(16'(sb.vlim), -16'(sb.vlim), 16'd30000);
    send_beat(16'(sb.vlim + 1), -16'(sb.vlim + 1), 16'd5000);
    end_burst();
  endtask

  initial begin
    #200000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults, corners, then random
    directed_beats();
    random_beats(320);

    // long receiver hold-off while the sender keeps offering
    hold_cycles = 300;
    random_beats(100);
    drain();

    // no idling stretch
    quiet = 1;
    random_beats(150);
    quiet = 0;

    // widest limit, tiny supply: heavy saturation; largest period
    set_config(16'hFFFF, 16'd1, 16'hFFFF);
    directed_beats();
    random_beats(150);

    // zero limit: all duties one half
    set_config(16'd0, 16'd3072, 16'd0);
    directed_beats();
    random_beats(60);

    // supply masked down to zero
    set_config(16'd2000, 16'h8000, 16'd999);
    directed_beats();
    random_beats(120);

    // unmapped index must be ignored
    drain();
    write_reg(REG_NONE, 16'h1234);
    random_beats(60);

    // large supply, widest limit
    set_config(16'd32767, 16'h7FFF, 16'd4199);
    random_beats(150);

    // random settings
    repeat (4) begin
      set_config(16'($urandom), 16'($urandom_range(32767, 1)), 16'($urandom));
      random_beats(60);
    end

    drain();
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d predictions never matched", $time, sb.pending.size());
      sb.errors++;
    end
    $display("Covered %0d input beats, %0d output beats checked, %0d register settings.",
             beats_sent, sb.checked, cfg_sets + 1);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ----- sine_pwm_inverse_park_clarke.f -----
hdl/spc_pkg.sv
hdl/spc_sincos.sv
hdl/spc_duty.sv
hdl/sine_pwm_inverse_park_clarke.sv
verif/testbench.sv
